>>> sv/ordd_pkg.sv
// Package with types, constants and register indexes of the drift detector.
`default_nettype none
package ordd_pkg;
	localparam int unsigned BaseDepth = 256;
	localparam int unsigned AddrW = $clog2(BaseDepth);
	localparam int unsigned CntW = AddrW + 1;
	localparam logic [15:0] RunMax = 16'hFFFF;
	localparam logic [47:0] ElapsedMax = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		REG_EWMA_WEIGHT = 3'd0,
		REG_OFFSET_LIMIT = 3'd1,
		REG_OFFSET_HOLD = 3'd2,
		REG_SAG_PERCENT = 3'd3,
		REG_RATE_HOLD = 3'd4,
		REG_BASELINE_TIME = 3'd5,
		REG_FIXED_RATE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic offset_present;
		logic signed [31:0] offset_value;
		logic rate_present;
		logic [31:0] rate_value;
		logic [31:0] tick_length;
	} tick_in_t;

	typedef struct packed {
		logic timing_flag;
		logic timing_rose;
		logic timing_fell;
		logic rate_flag;
		logic rate_rose;
		logic rate_fell;
		logic signed [31:0] offset_average;
		logic [31:0] reference_rate;
	} tick_out_t;

	typedef struct packed {
		logic [2:0] index;
		logic [31:0] data;
	} cfg_wr_t;

	// Saturating increment for run counters.
	function automatic logic [15:0] run_inc(input logic [15:0] r);
		return (r == RunMax) ? RunMax : r + 16'd1;
	endfunction
endpackage
`default_nettype wire

>>> sv/ordd_if.sv
// Valid/ready channel interface carrying one payload type.
`default_nettype none
interface ordd_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> sv/ordd_cfg_if.sv
// Configuration write channel interface.
`default_nettype none
interface ordd_cfg_if ();
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/offset_and_rate_drift_detector.sv
// Offset and rate drift detector: top level with sequencer and shared multiplier.
// Closing the learning window runs a rank-counting median over the n stored samples
// (n up to 256) through the one read port. One request at a time: input is ready again
// the cycle after the result is taken, unless a configuration write is pending.
// Reset clears all flags, runs, the average and learning; a register write does too.
`default_nettype none
module offset_and_rate_drift_detector (
	input wire clk,
	input wire arst_n,
	ordd_if.sink in_ch,
	ordd_if.source out_ch,
	ordd_cfg_if.sink cfg
);
	import ordd_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_MUL_A = 13'b0000000000010,
		ST_MUL_B = 13'b0000000000100,
		ST_AVG = 13'b0000000001000,
		ST_TIMING = 13'b0000000010000,
		ST_RATE = 13'b0000000100000,
		ST_RMUL_A = 13'b0000001000000,
		ST_RMUL_B = 13'b0000010000000,
		ST_RCMP = 13'b0000100000000,
		ST_MED_RD = 13'b0001000000000,
		ST_MED_LD = 13'b0010000000000,
		ST_MED_CMP = 13'b0100000000000,
		ST_OUT = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [16:0] weight_q;
	logic [30:0] limit_q;
	logic [15:0] thold_q;
	logic [6:0] sag_q;
	logic [15:0] rhold_q;
	logic [31:0] btime_q;
	logic [31:0] fixed_q;

	// Detector state.
	logic loaded_q, tflag_q, rflag_q;
	logic signed [31:0] avg_q;
	logic [15:0] thigh_q, tlow_q, rlow_q, rok_q;
	logic [31:0] learned_q;
	logic [CntW-1:0] count_q;
	logic [47:0] elapsed_q;
	logic [31:0] store_q [BaseDepth];

	// Working registers.
	tick_in_t tick_q;
	tick_out_t res_q;
	tick_out_t out_c;
	logic signed [32:0] mul_a_q;
	logic signed [17:0] mul_b_q;
	logic signed [50:0] prod_q;
	logic signed [50:0] acc_q;
	logic [AddrW-1:0] med_i_q, med_j_q;
	logic [31:0] med_v_q, rd_q;
	logic [CntW-1:0] less_q, leq_q;
	logic [CntW-1:0] scan_n_q;

	// Configuration has priority; both channels are served only in idle.
	logic cfg_hit;
	assign cfg.ready = (state_q == ST_IDLE);
	assign cfg_hit = cfg.valid && cfg.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign out_ch.valid = (state_q == ST_OUT);

	// The result carries the live flags and values with the pulses of this request.
	always_comb begin
		out_c = res_q;
		out_c.timing_flag = tflag_q;
		out_c.rate_flag = rflag_q;
		out_c.offset_average = avg_q;
		out_c.reference_rate = learned_q;
	end
	assign out_ch.payload = out_c;

	// Shared signed multiplier, one product per cycle.
	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
	end

	// Clamped constants for the current tick.
	logic [16:0] w_c;
	logic [6:0] p_c;
	assign w_c = (weight_q > 17'd65536) ? 17'd65536 : weight_q;
	assign p_c = (sag_q > 7'd100) ? 7'd100 : sag_q;

	logic [31:0] mag_c;
	assign mag_c = avg_q[31] ? 32'(-{1'b1, avg_q}) : 32'(avg_q);
	logic [47:0] el_sum;
	logic [48:0] el_raw;
	assign el_raw = {1'b0, elapsed_q} + 49'(tick_q.tick_length);
	assign el_sum = el_raw[48] ? ElapsedMax : el_raw[47:0];

	// Sample store read port, and the write of each learning sample.
	always_ff @(posedge clk) begin
		rd_q <= store_q[med_j_q];
		if (state_q == ST_RATE && tick_q.rate_present && learned_q == 32'd0
				&& count_q < CntW'(BaseDepth))
			store_q[count_q[AddrW-1:0]] <= tick_q.rate_value;
	end

	logic signed [50:0] blend_c;
	assign blend_c = acc_q + prod_q + 51'sd32768;

	// Rank counting of the stored sample under scan against the candidate.
	logic [CntW-1:0] less_n, leq_n;
	logic [CntW-1:0] half_c;
	assign half_c = count_q >> 1;
	assign less_n = less_q + CntW'(rd_q < med_v_q);
	assign leq_n = leq_q + CntW'(rd_q <= med_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			weight_q <= 17'd6554; limit_q <= 31'd1000; thold_q <= 16'd3;
			sag_q <= 7'd20; rhold_q <= 16'd3; btime_q <= 32'd5000000;
			fixed_q <= 32'd0;
			loaded_q <= 1'b0; tflag_q <= 1'b0; rflag_q <= 1'b0; avg_q <= '0;
			thigh_q <= '0; tlow_q <= '0; rlow_q <= '0; rok_q <= '0;
			learned_q <= '0; count_q <= '0; elapsed_q <= '0;
			tick_q <= '0; res_q <= '0; mul_a_q <= '0; mul_b_q <= '0; acc_q <= '0;
			med_i_q <= '0; med_j_q <= '0; med_v_q <= '0;
			less_q <= '0; leq_q <= '0; scan_n_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_hit) begin
						case (cfg.index)
							REG_EWMA_WEIGHT: weight_q <= cfg.data[16:0];
							REG_OFFSET_LIMIT: limit_q <= cfg.data[30:0];
							REG_OFFSET_HOLD: thold_q <= cfg.data[15:0];
							REG_SAG_PERCENT: sag_q <= cfg.data[6:0];
							REG_RATE_HOLD: rhold_q <= cfg.data[15:0];
							REG_BASELINE_TIME: btime_q <= cfg.data;
							REG_FIXED_RATE: fixed_q <= cfg.data;
							default: ;
						endcase
						if (cfg.index <= REG_FIXED_RATE) begin
							loaded_q <= 1'b0; tflag_q <= 1'b0; rflag_q <= 1'b0;
							avg_q <= '0; thigh_q <= '0; tlow_q <= '0;
							rlow_q <= '0; rok_q <= '0; count_q <= '0;
							elapsed_q <= '0;
							learned_q <= (cfg.index == REG_FIXED_RATE) ? cfg.data : fixed_q;
						end
					end else if (in_ch.valid && in_ch.ready) begin
						tick_q <= in_ch.payload;
						res_q <= '0;
						mul_a_q <= {in_ch.payload.offset_value[31], in_ch.payload.offset_value};
						mul_b_q <= 18'({1'b0, w_c});
						state_q <= in_ch.payload.offset_present ? ST_MUL_A : ST_RATE;
					end
				end
				// w * x is in flight; queue (65536 - w) * avg.
				ST_MUL_A: begin
					mul_a_q <= {avg_q[31], avg_q};
					mul_b_q <= 18'h10000 - {1'b0, w_c};
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					acc_q <= prod_q;
					state_q <= ST_AVG;
				end
				// The first offset loads the average; later ones round half up by an arithmetic shift of the biased sum.
				ST_AVG: begin
					if (!loaded_q) begin
						avg_q <= tick_q.offset_value;
						loaded_q <= 1'b1;
					end else begin
						avg_q <= 32'(blend_c >>> 16);
					end
					state_q <= ST_TIMING;
				end
				ST_TIMING: begin
					if (!tflag_q) begin
						if ({1'b0, mag_c} > {2'b0, limit_q}) begin
							thigh_q <= run_inc(thigh_q);
							if (run_inc(thigh_q) >= thold_q) begin
								tflag_q <= 1'b1; res_q.timing_rose <= 1'b1; tlow_q <= '0;
							end
						end else thigh_q <= '0;
					end else begin
						if ({3'b0, mag_c} * 35'd5 < {2'b0, limit_q, 2'b0}) begin
							tlow_q <= run_inc(tlow_q);
							if (run_inc(tlow_q) >= thold_q) begin
								tflag_q <= 1'b0; res_q.timing_fell <= 1'b1; thigh_q <= '0;
							end
						end else tlow_q <= '0;
					end
					state_q <= ST_RATE;
				end
				ST_RATE: begin
					if (!tick_q.rate_present) state_q <= ST_OUT;
					else if (learned_q == 32'd0) begin
						elapsed_q <= el_sum;
						if (count_q < CntW'(BaseDepth)) count_q <= count_q + CntW'(1);
						if (el_sum >= 48'(btime_q)
								|| count_q + CntW'(1) >= CntW'(BaseDepth)) begin
							med_i_q <= '0; med_j_q <= '0;
							state_q <= ST_MED_RD;
						end else state_q <= ST_OUT;
					end else begin
						// Left side: rate * 100 or 500.
						mul_a_q <= {1'b0, tick_q.rate_value};
						mul_b_q <= rflag_q ? 18'sd500 : 18'sd100;
						state_q <= ST_RMUL_A;
					end
				end
				ST_RMUL_A: begin
					mul_a_q <= {1'b0, learned_q};
					mul_b_q <= rflag_q ? 18'(10'd500 - 10'({p_c, 2'b0}))
						: 18'(8'd100 - 8'(p_c));
					state_q <= ST_RMUL_B;
				end
				ST_RMUL_B: begin
					acc_q <= prod_q;
					state_q <= ST_RCMP;
				end
				ST_RCMP: begin
					if (!rflag_q) begin
						if (acc_q < prod_q) begin
							rlow_q <= run_inc(rlow_q);
							if (run_inc(rlow_q) >= rhold_q) begin
								rflag_q <= 1'b1; res_q.rate_rose <= 1'b1; rok_q <= '0;
							end
						end else rlow_q <= '0;
					end else begin
						if (acc_q >= prod_q) begin
							rok_q <= run_inc(rok_q);
							if (run_inc(rok_q) >= rhold_q) begin
								rflag_q <= 1'b0; res_q.rate_fell <= 1'b1; rlow_q <= '0;
							end
						end else rok_q <= '0;
					end
					state_q <= ST_OUT;
				end
				// Median by rank counting: the store is read at candidate i, then at
				// every j in turn; read data are registered and arrive in the cycle after the address.
				ST_MED_RD: begin
					if ({1'b0, med_i_q} >= count_q) begin
						learned_q <= '0; count_q <= '0; state_q <= ST_OUT;
					end else begin
						med_j_q <= '0;
						state_q <= ST_MED_LD;
					end
				end
				ST_MED_LD: begin
					med_v_q <= rd_q;
					med_j_q <= AddrW'(1);
					less_q <= '0; leq_q <= '0; scan_n_q <= '0;
					state_q <= ST_MED_CMP;
				end
				ST_MED_CMP: begin
					less_q <= less_n; leq_q <= leq_n;
					scan_n_q <= scan_n_q + CntW'(1);
					if (scan_n_q == count_q - CntW'(1)) begin
						if (less_n <= half_c && half_c < leq_n) begin
							learned_q <= med_v_q; count_q <= '0; state_q <= ST_OUT;
						end else begin
							med_i_q <= med_i_q + AddrW'(1);
							med_j_q <= med_i_q + AddrW'(1);
							state_q <= ST_MED_RD;
						end
					end else begin
						med_j_q <= med_j_q + AddrW'(1);
					end
				end
				ST_OUT: begin
					if (out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	initial_state_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> state_q != ST_IDLE)
		else $error("tick accepted without leaving idle");
	single_handshake_a: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg.valid && cfg.ready && in_ch.valid && in_ch.ready))
		else $error("config and tick both accepted");
	out_only_in_out_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input ready while result pending");
	count_bound_a: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(BaseDepth))
		else $error("sample count over depth");
endmodule
`default_nettype wire

>>> test/offset_and_rate_drift_detector_test.sv
// Testbench of the offset and rate drift detector: directed and random ticks checked against a predictor.
`default_nettype none
module offset_and_rate_drift_detector_test;
	import ordd_pkg::*;

	// Tracks the detector state and holds the tick results still to come.
	class drift_scoreboard;
		logic [16:0] weight;
		logic [30:0] limit;
		logic [15:0] offset_hold;
		logic [6:0] sag;
		logic [15:0] rate_hold;
		logic [31:0] window_len;
		logic [31:0] fixed_rate;
		bit avg_valid, timing_on, rate_on;
		logic signed [31:0] avg;
		logic [15:0] high_run, low_run, sag_run, ok_run;
		logic [31:0] ref_rate;
		logic [31:0] samples[$];
		longint unsigned elapsed;
		tick_out_t results_due[$];
		int errors;

		function new();
			weight = 17'd6554;
			limit = 31'd1000;
			offset_hold = 16'd3;
			sag = 7'd20;
			rate_hold = 16'd3;
			window_len = 32'd5000000;
			fixed_rate = 32'd0;
			errors = 0;
			clear();
		endfunction

		function void clear();
			avg_valid = 0;
			avg = 0;
			timing_on = 0;
			high_run = 0;
			low_run = 0;
			rate_on = 0;
			sag_run = 0;
			ok_run = 0;
			ref_rate = fixed_rate;
			samples.delete();
			elapsed = 0;
		endfunction

		// A register write stores the value and restarts every detector.
		function void configure(reg_idx_t idx, logic [31:0] d);
			case (idx)
				REG_EWMA_WEIGHT: weight = d[16:0];
				REG_OFFSET_LIMIT: limit = d[30:0];
				REG_OFFSET_HOLD: offset_hold = d[15:0];
				REG_SAG_PERCENT: sag = d[6:0];
				REG_RATE_HOLD: rate_hold = d[15:0];
				REG_BASELINE_TIME: window_len = d;
				REG_FIXED_RATE: fixed_rate = d;
				default: return;
			endcase
			clear();
		endfunction

		function logic [15:0] bump(logic [15:0] r);
			return (r == 16'hFFFF) ? r : r + 16'd1;
		endfunction

		function void note_tick(tick_in_t t);
			tick_out_t r;
			longint w, s, mag;
			longint unsigned rate, e, p;
			logic [31:0] sorted[$];
			r = '0;
			// Timing detector moves only on ticks that carry an offset.
			if (t.offset_present) begin
				if (!avg_valid) begin
					avg = t.offset_value;
					avg_valid = 1;
				end else begin
					w = (weight > 17'd65536) ? 65536 : longint'(weight);
					s = w * longint'(t.offset_value) + (65536 - w) * longint'(avg);
					s = (s + 32768) >>> 16;
					avg = s[31:0];
				end
				mag = (avg < 0) ? -longint'(avg) : longint'(avg);
				if (!timing_on) begin
					if (mag > longint'(limit)) begin
						high_run = bump(high_run);
						if (high_run >= offset_hold) begin
							timing_on = 1;
							r.timing_rose = 1;
							low_run = 0;
						end
					end else begin
						high_run = 0;
					end
				end else begin
					if (5 * mag < 4 * longint'(limit)) begin
						low_run = bump(low_run);
						if (low_run >= offset_hold) begin
							timing_on = 0;
							r.timing_fell = 1;
							high_run = 0;
						end
					end else begin
						low_run = 0;
					end
				end
			end
			// Rate detector: learn the baseline first, then compare.
			if (t.rate_present) begin
				rate = t.rate_value;
				if (ref_rate == 0) begin
					if (samples.size() < BaseDepth)
						samples = {samples, t.rate_value};
					elapsed += longint'(t.tick_length);
					if (elapsed > 64'hFFFF_FFFF_FFFF)
						elapsed = 64'hFFFF_FFFF_FFFF;
					if (elapsed >= window_len || samples.size() >= BaseDepth) begin
						sorted = samples;
						sorted.sort();
						ref_rate = sorted[sorted.size() / 2];
						samples.delete();
					end
				end else begin
					e = ref_rate;
					p = (sag > 7'd100) ? 100 : longint'(sag);
					if (!rate_on) begin
						if (100 * rate < e * (100 - p)) begin
							sag_run = bump(sag_run);
							if (sag_run >= rate_hold) begin
								rate_on = 1;
								r.rate_rose = 1;
								ok_run = 0;
							end
						end else begin
							sag_run = 0;
						end
					end else begin
						if (500 * rate >= e * (500 - 4 * p)) begin
							ok_run = bump(ok_run);
							if (ok_run >= rate_hold) begin
								rate_on = 0;
								r.rate_fell = 1;
								sag_run = 0;
							end
						end else begin
							ok_run = 0;
						end
					end
				end
			end
			r.timing_flag = timing_on;
			r.rate_flag = rate_on;
			r.offset_average = avg;
			r.reference_rate = ref_rate;
			results_due = {results_due, r};
		endfunction

		function void mismatch(string field, longint want, longint got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_result(tick_out_t got);
			tick_out_t want;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = results_due.pop_front();
			if (got.timing_flag !== want.timing_flag)
				mismatch("timing_flag", want.timing_flag, got.timing_flag);
			if (got.timing_rose !== want.timing_rose)
				mismatch("timing_rose", want.timing_rose, got.timing_rose);
			if (got.timing_fell !== want.timing_fell)
				mismatch("timing_fell", want.timing_fell, got.timing_fell);
			if (got.rate_flag !== want.rate_flag)
				mismatch("rate_flag", want.rate_flag, got.rate_flag);
			if (got.rate_rose !== want.rate_rose)
				mismatch("rate_rose", want.rate_rose, got.rate_rose);
			if (got.rate_fell !== want.rate_fell)
				mismatch("rate_fell", want.rate_fell, got.rate_fell);
			if (got.offset_average !== want.offset_average)
				mismatch("offset_average", want.offset_average, got.offset_average);
			if (got.reference_rate !== want.reference_rate)
				mismatch("reference_rate", want.reference_rate, got.reference_rate);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	ordd_if #(.T(tick_in_t)) in_ch ();
	ordd_if #(.T(tick_out_t)) out_ch ();
	ordd_cfg_if cfg ();

	offset_and_rate_drift_detector i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg(cfg.sink)
	);

	drift_scoreboard board = new();
	bit steady = 0;
	bit hold_off_req = 0;
	int idle_cycles = 0;
	longint lim_scale = 1000;
	longint nominal_rate = 50000;
	localparam int WatchdogLimit = 400000;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.payload = '0;
		cfg.valid = 0;
		cfg.index = REG_EWMA_WEIGHT;
		cfg.data = '0;
		out_ch.ready = 0;
	end

	// Receiver: random stalls, or one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ch.ready <= 0;
				repeat (400) @(posedge clk);
				hold_off_req = 0;
			end else begin
				out_ch.ready <= steady || ($urandom_range(99) >= 28);
			end
		end
	end

	// Note accepted requests and check accepted results.
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			board.note_tick(in_ch.payload);
		if (out_ch.valid && out_ch.ready)
			board.check_result(out_ch.payload);
	end

	// Watchdog on cycles with no handshake at all.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_tick(tick_in_t t);
		if (!steady && $urandom_range(99) < 28) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.payload <= t;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (board.results_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		board.configure(idx, d);
	endtask

	task automatic write_all(logic [31:0] w, logic [31:0] lim, logic [31:0] oh,
			logic [31:0] sg, logic [31:0] rh, logic [31:0] bt, logic [31:0] fr);
		drain();
		write_reg(REG_EWMA_WEIGHT, w);
		write_reg(REG_OFFSET_LIMIT, lim);
		write_reg(REG_OFFSET_HOLD, oh);
		write_reg(REG_SAG_PERCENT, sg);
		write_reg(REG_RATE_HOLD, rh);
		write_reg(REG_BASELINE_TIME, bt);
		write_reg(REG_FIXED_RATE, fr);
		@(posedge clk);
	endtask

	function automatic tick_in_t make_tick(bit op, logic [31:0] ov, bit rp,
			logic [31:0] rv, logic [31:0] tl);
		tick_in_t t;
		t.offset_present = op;
		t.offset_value = ov;
		t.rate_present = rp;
		t.rate_value = rv;
		t.tick_length = tl;
		return t;
	endfunction

	// Mostly plausible ticks near the thresholds, some pure noise.
	function automatic tick_in_t random_tick();
		longint ov, rv;
		if ($urandom_range(99) < 12)
			return make_tick($urandom_range(1), $urandom(), $urandom_range(1),
				$urandom(), $urandom());
		ov = longint'($urandom_range(0, 2 * lim_scale + 10));
		if ($urandom_range(1))
			ov = -ov;
		rv = nominal_rate * $urandom_range(50, 120) / 100;
		return make_tick($urandom_range(99) < 85, ov[31:0], $urandom_range(99) < 85,
			rv[31:0], $urandom_range(500, 1500));
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, first load, learning close and both flags.
		send_tick(make_tick(1, 32'h7FFF_FFFF, 0, 0, 0));
		send_tick(make_tick(1, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_tick(make_tick(0, 32'hFFFF_FFFF, 0, 0, 0));
		send_tick(make_tick(1, 32'h8000_0000, 0, 0, 0));
		send_tick(make_tick(1, 32'h8000_0000, 0, 0, 0));
		send_tick(make_tick(1, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, 0, 0, 0));
		send_tick(make_tick(1, 0, 0, 0, 0));
		send_tick(make_tick(0, 0, 1, 0, 0));
		send_tick(make_tick(0, 0, 1, 32'hFFFF_FFFF, 32'd5000000));
		repeat (3) send_tick(make_tick(0, 0, 1, 0, 32'hFFFF_FFFF));
		send_tick(make_tick(0, 0, 0, 0, 0));
		repeat (3) send_tick(make_tick(1, 32'd5, 1, 32'hFFFF_FFFF, 0));

		// Lowest settings but for the full weight: zero holds, zero window, zero median restarts learning.
		write_all(32'd65536, 0, 0, 0, 0, 0, 0);
		send_tick(make_tick(0, 0, 1, 0, 0));
		send_tick(make_tick(1, 32'd1, 1, 32'd7, 0));
		send_tick(make_tick(1, 32'hFFFF_FFFF, 1, 32'd6, 0));
		lim_scale = 4;
		repeat (12) send_tick(random_tick());

		// Highest settings, including weight and sag beyond their range.
		write_all(32'h1FFFF, 32'h7FFF_FFFF, 32'hFFFF, 32'h7F, 32'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (8) send_tick(make_tick($urandom_range(1), $urandom(), 1, $urandom(),
			$urandom()));

		// Learn a baseline over a short window while the receiver holds off.
		write_all(0, 32'd100, 32'd1, 32'd50, 32'd1, 32'd20, 0);
		steady = 1;
		hold_off_req = 1;
		for (int i = 0; i < 24; i++)
			send_tick(make_tick(0, 0, 1, $urandom_range(40000, 60000), 32'd1));
		steady = 0;
		lim_scale = 100;
		repeat (4) send_tick(random_tick());

		// Working settings with a short learning window.
		write_all($urandom_range(2000, 40000), 32'd1000, 32'd2, 32'd20, 32'd2,
			32'd3000, 0);
		lim_scale = 1000;
		repeat (15) send_tick(random_tick());
		drain();
		steady = 1;
		repeat (10) send_tick(random_tick());
		steady = 0;

		// Fixed expected rate.
		write_all(32'd50000, 32'd500, 32'd1, 32'd35, 32'd2, 32'd1000, 32'd50000);
		lim_scale = 500;
		repeat (12) send_tick(random_tick());

		drain();
		if (board.errors == 0 && board.results_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> sim.f
sv/ordd_pkg.sv
sv/ordd_if.sv
sv/ordd_cfg_if.sv
sv/offset_and_rate_drift_detector.sv
test/offset_and_rate_drift_detector_test.sv
